// ===== hdl/modexp_pkg.sv =====
package modexp_pkg;

   // Default modulus width; every product of two residues fits in twice this width.
   localparam int MODULUS_BITS_DEF = 32;

   // Field widths of the request and response items.
   localparam int BASE_W     = 63;
   localparam int EXPONENT_W = 63;
   localparam int MODULUS_W  = 32;
   localparam int POWER_W    = 32;

   // Request data layout, lowest field first, padded to whole bytes.
   localparam int BASE_LSB     = 0;
   localparam int EXPONENT_LSB = BASE_LSB + BASE_W;
   localparam int MODULUS_LSB  = EXPONENT_LSB + EXPONENT_W;
   localparam int REQ_FIELDS_W = MODULUS_LSB + MODULUS_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((POWER_W + 7) / 8) * 8;

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_NORM  = 10'b00_0000_0010,
      S_DIV   = 10'b00_0000_0100,
      S_SHIFT = 10'b00_0000_1000,
      S_EST   = 10'b00_0001_0000,
      S_QM    = 10'b00_0010_0000,
      S_FIX   = 10'b00_0100_0000,
      S_BIT   = 10'b00_1000_0000,
      S_MUL   = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } state_type;

   // Which modular product is being formed by the shared unit.
   typedef enum logic [1:0] {
      OP_BASE = 2'd0,
      OP_ACC  = 2'd1,
      OP_SQR  = 2'd2
   } op_type;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// Modular exponentiation: power_mod = base ** exponent mod modulus.
// Requests come in on the req_ stream (base, exponent, modulus packed in req_tdata),
// results leave on the rsp_ stream, one per request, in request order.
// A request is taken only while the block is idle; one request is worked at a time.
// Setup per request: the modulus is normalized by shifting until its top bit is set,
// then restoring division gives the Barrett constant, then the base is reduced one
// MODULUS_BITS-wide digit at a time through the shift, estimate, quotient and fix steps.
// Each exponent bit up to the highest set one then costs the bit test and the squaring
// (none after the highest set bit), plus a product into the result when the bit is set;
// all products use one shared multiplier with Barrett reduction. The next request can
// be taken from the cycle after the result enters the output register.
// A zero modulus, or a base that reduces to zero, gives 0 right after that check.
// The result sits in an output register; while the receiver stalls, the block
// can still take one more request and holds its result until the register frees.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_tvalid.
module modular_exponentiation #(
   parameter int MODULUS_BITS = modexp_pkg::MODULUS_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // base [62:0], exponent [125:63], modulus [157:126], zero fill [159:158]
   input  logic [modexp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // power_mod [31:0]
   output logic [modexp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import modexp_pkg::*;

   localparam int MW      = MODULUS_BITS;
   localparam int NDIG    = (BASE_W + MW - 1) / MW;
   localparam int BPAD_W  = NDIG * MW;
   localparam int DIG_W   = $clog2(NDIG);
   localparam int CNT_W   = $clog2(2 * MW + 1);
   localparam int SH_W    = $clog2(MW);
   localparam int PROD_W  = 2 * MW + 3;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [MW-1:0]           mn_ff, mn_in;        // normalized modulus
   logic [SH_W-1:0]         sh_ff, sh_in;        // normalizing shift
   logic [MW-1:0]           rem_ff, rem_in;      // division remainder
   logic [MW+1:0]           mu_ff, mu_in;        // Barrett constant
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DIG_W-1:0]        dig_ff, dig_in;
   logic [BPAD_W-1:0]       bsh_ff, bsh_in;      // base digits, top first
   logic [EXPONENT_W-1:0]   exp_ff, exp_in;
   logic [MW-1:0]           sq_ff, sq_in;        // running power
   logic [MW-1:0]           acc_ff, acc_in;      // running result
   logic [2*MW-1:0]         x_ff, x_in;          // shifted value to reduce
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic [MW+1:0]           mul_a, mul_b;
   logic [2*MW+3:0]         mul_p;
   logic [MW:0]             div_t;
   logic                    div_ge;
   logic [2*MW-1:0]         red_src;
   logic [MW+1:0]           red_r, red_m1, red_m2, red_c;
   logic [MW-1:0]           red_res;
   logic [MW-1:0]           req_mod;

   // Shared multiplier; operands chosen by the sequencer state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL: begin
            mul_a = {2'b00, (op_ff == OP_ACC) ? acc_ff : sq_ff};
            mul_b = {2'b00, sq_ff};
         end
         S_EST: begin
            mul_a = {1'b0, x_ff[2*MW-1:MW-1]};
            mul_b = mu_ff;
         end
         S_QM: begin
            mul_a = prod_ff[2*MW+2:MW+1];
            mul_b = {2'b00, mn_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // One step of restoring division of 2**(2*MW) by the normalized modulus.
   always_comb begin
      div_t  = {rem_ff, (cnt_ff == '0)};
      div_ge = (div_t >= {1'b0, mn_ff});
   end

   // Barrett remainder with up to two corrections, then undo the normalizing shift.
   always_comb begin
      red_src = (op_ff == OP_BASE) ? {sq_ff, bsh_ff[BPAD_W-1 -: MW]} : prod_ff[2*MW-1:0];
      red_r   = x_ff[MW+1:0] - prod_ff[MW+1:0];
      red_m1  = {2'b00, mn_ff};
      red_m2  = {1'b0, mn_ff, 1'b0};
      if (red_r >= red_m2) begin
         red_c = red_r - red_m2;
      end else if (red_r >= red_m1) begin
         red_c = red_r - red_m1;
      end else begin
         red_c = red_r;
      end
      red_res = red_c[MW-1:0] >> sh_ff;
   end

   assign req_mod = req_tdata[MODULUS_LSB +: MW];

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      mn_in         = mn_ff;
      sh_in         = sh_ff;
      rem_in        = rem_ff;
      mu_in         = mu_ff;
      cnt_in        = cnt_ff;
      dig_in        = dig_ff;
      bsh_in        = bsh_ff;
      exp_in        = exp_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      x_in          = x_ff;
      prod_in       = prod_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               bsh_in = BPAD_W'(req_tdata[BASE_LSB +: BASE_W]);
               exp_in = req_tdata[EXPONENT_LSB +: EXPONENT_W];
               mn_in  = req_mod;
               sh_in  = '0;
               acc_in = '0;
               state_in = (req_mod == '0) ? S_DONE : S_NORM;
            end
         end
         S_NORM: begin
            if (mn_ff[MW-1]) begin
               rem_in   = '0;
               mu_in    = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               mn_in = {mn_ff[MW-2:0], 1'b0};
               sh_in = sh_ff + 1'b1;
            end
         end
         S_DIV: begin
            rem_in = div_ge ? MW'(div_t - {1'b0, mn_ff}) : div_t[MW-1:0];
            mu_in  = {mu_ff[MW:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2 * MW)) begin
               sq_in    = '0;
               dig_in   = '0;
               op_in    = OP_BASE;
               state_in = S_SHIFT;
            end
         end
         S_MUL: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            x_in = red_src << sh_ff;
            if (op_ff == OP_BASE) begin
               bsh_in = bsh_ff << MW;
            end
            state_in = S_EST;
         end
         S_EST: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = S_QM;
         end
         S_QM: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = S_FIX;
         end
         S_FIX: begin
            case (op_ff)
               OP_BASE: begin
                  sq_in  = red_res;
                  dig_in = dig_ff + 1'b1;
                  if (dig_ff == DIG_W'(NDIG - 1)) begin
                     if (red_res == '0) begin
                        acc_in   = '0;
                        state_in = S_DONE;
                     end else begin
                        acc_in   = MW'(1);
                        state_in = S_BIT;
                     end
                  end else begin
                     state_in = S_SHIFT;
                  end
               end
               OP_ACC: begin
                  acc_in = red_res;
                  if ((exp_ff >> 1) == '0) begin
                     state_in = S_DONE;
                  end else begin
                     op_in    = OP_SQR;
                     state_in = S_MUL;
                  end
               end
               OP_SQR: begin
                  sq_in    = red_res;
                  exp_in   = exp_ff >> 1;
                  state_in = S_BIT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_BIT: begin
            if (exp_ff == '0) begin
               state_in = S_DONE;
            end else begin
               op_in    = exp_ff[0] ? OP_ACC : OP_SQR;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            // Wait until the output register is free, then hand over the result.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_W'(acc_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      op_ff        <= op_in;
      mn_ff        <= mn_in;
      sh_ff        <= sh_in;
      rem_ff       <= rem_in;
      mu_ff        <= mu_in;
      cnt_ff       <= cnt_in;
      dig_ff       <= dig_in;
      bsh_ff       <= bsh_in;
      exp_ff       <= exp_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      prod_ff      <= prod_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
